// ----- hw/rtl/dsfw_pkg.sv -----
// Shared types, constants and lookup functions for the decimal segment field writer.
// No dependencies; every module of the block imports this package.
package dsfw_pkg;

    // Controller command bytes: column address high nibble (0x10 | 1), then low nibble
    localparam logic [7:0] CMD_COL_HI = 8'h11;
    localparam logic [7:0] CMD_COL_LO = 8'h07;

    // Flag byte values
    localparam logic [7:0] FLAG_FIRST = 8'h0F;
    localparam logic [7:0] FLAG_NEXT  = 8'h08;
    localparam logic [7:0] FLAG_CLEAR = 8'h00;

    // Write sequence: two commands, flag, then five digits as two writes each
    localparam int unsigned WRITES_PER_ITEM = 13;
    localparam int unsigned STEP_W          = 4;
    localparam logic [STEP_W-1:0] STEP_COL_HI = 4'd0;
    localparam logic [STEP_W-1:0] STEP_COL_LO = 4'd1;
    localparam logic [STEP_W-1:0] STEP_FLAG   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(WRITES_PER_ITEM - 1);

    localparam int unsigned NUM_DIGITS = 5;
    localparam int unsigned DIG_W      = 3;

    // Queue entry handed from front to back
    typedef struct packed {
        logic [15:0] value;
        logic        blank;
        logic [7:0]  flag;
    } t_job;

    // One controller write
    typedef struct packed {
        logic       is_command;
        logic [7:0] bus_byte;
        logic       last;
    } t_wr;

    // Result of one digit extraction step
    typedef struct packed {
        logic [3:0]  digit;
        logic [15:0] rest;
    } t_split;

    // Power of ten for digit position, most significant first
    function automatic logic [16:0] pow10(input logic [DIG_W-1:0] idx);
        logic [16:0] p;
        unique case (idx)
            3'd0:    p = 17'd10000;
            3'd1:    p = 17'd1000;
            3'd2:    p = 17'd100;
            3'd3:    p = 17'd10;
            3'd4:    p = 17'd1;
            default: p = 17'd1;
        endcase
        return p;
    endfunction

    // One decimal digit: parallel compares against the nine multiples of the position weight
    function automatic t_split digit_split(input logic [15:0] rem,
                                           input logic [DIG_W-1:0] idx);
        t_split      res;
        logic [16:0] p;
        logic [16:0] prod;
        logic [16:0] sub;
        p        = pow10(idx);
        sub      = '0;
        res      = '0;
        for (int k = 1; k <= 9; k++) begin
            prod = p * 17'(k);
            if ({1'b0, rem} >= prod) begin
                res.digit = 4'(k);
                sub       = prod;
            end
        end
        res.rest = 16'({1'b0, rem} - sub);
        return res;
    endfunction

    // Segment pattern of a decimal digit
    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] s;
        unique case (digit)
            4'd0:    s = 8'hAF;
            4'd1:    s = 8'hA0;
            4'd2:    s = 8'hCB;
            4'd3:    s = 8'hE9;
            4'd4:    s = 8'hE4;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h6F;
            4'd7:    s = 8'hA8;
            4'd8:    s = 8'hEF;
            4'd9:    s = 8'hED;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// ----- hw/rtl/dsfw_front.sv -----
// Front end: accepts input items, works out the flag byte and builds a queue entry.
// Depends on dsfw_pkg.
module dsfw_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [15:0]   i_value,
    input  logic [1:0]    i_mode,
    output logic          o_ready,
    input  logic          i_q_full,
    output logic          o_push,
    output dsfw_pkg::t_job o_job
);
    import dsfw_pkg::*;

    logic r_first_call;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Flag byte: cleared by mode bit 0, else depends on first call after reset
    always_comb begin
        o_job.value = i_value;
        o_job.blank = i_mode[1];
        if (i_mode[0]) begin
            o_job.flag = FLAG_CLEAR;
        end else if (r_first_call) begin
            o_job.flag = FLAG_FIRST;
        end else begin
            o_job.flag = FLAG_NEXT;
        end
    end

    // First-call marker drops on the first accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_call <= 1'b1;
        end else if (o_push) begin
            r_first_call <= 1'b0;
        end
    end

endmodule

// ----- hw/rtl/dsfw_queue.sv -----
// Two-entry queue between front and back end.
// Depends on dsfw_pkg for the entry type.
module dsfw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dsfw_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output dsfw_pkg::t_job o_job
);
    import dsfw_pkg::*;

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// ----- hw/rtl/dsfw_back.sv -----
// Back end: sequences the thirteen controller writes of one entry, two writes per digit,
// into a registered output stage. Depends on dsfw_pkg.
module dsfw_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  dsfw_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output dsfw_pkg::t_wr  o_wr
);
    import dsfw_pkg::*;

    logic              r_busy,  n_busy;
    logic [STEP_W-1:0] r_step,  n_step;
    logic [DIG_W-1:0]  r_dig,   n_dig;
    logic [15:0]       r_rem,   n_rem;
    logic [7:0]        r_seg,   n_seg;
    logic [7:0]        r_flag,  n_flag;
    logic              r_blank, n_blank;
    logic              r_out_valid;
    t_wr               r_out;

    logic   w_adv;
    logic   w_emit;
    t_wr    w_wr;
    t_split w_split;
    logic [7:0] w_seg;

    assign w_adv   = !r_out_valid || i_ready;
    assign o_valid = r_out_valid;
    assign o_wr    = r_out;

    // Current digit and its segment byte
    always_comb begin
        w_split = digit_split(r_rem, r_dig);
        if (r_blank || (r_dig == '0 && w_split.digit == 4'd0)) begin
            w_seg = 8'h00;
        end else begin
            w_seg = seg_of(w_split.digit);
        end
    end

    // Write for the current step
    always_comb begin
        w_wr.last = (r_step == STEP_LAST);
        priority if (r_step == STEP_COL_HI) begin
            w_wr.is_command = 1'b1;
            w_wr.bus_byte   = CMD_COL_HI;
        end else if (r_step == STEP_COL_LO) begin
            w_wr.is_command = 1'b1;
            w_wr.bus_byte   = CMD_COL_LO;
        end else if (r_step == STEP_FLAG) begin
            w_wr.is_command = 1'b0;
            w_wr.bus_byte   = r_flag;
        end else if (r_step[0]) begin
            w_wr.is_command = 1'b0;
            w_wr.bus_byte   = w_seg;
        end else begin
            w_wr.is_command = 1'b0;
            w_wr.bus_byte   = {4'h0, r_seg[7:4]};
        end
    end

    // Sequencer
    always_comb begin
        n_busy  = r_busy;
        n_step  = r_step;
        n_dig   = r_dig;
        n_rem   = r_rem;
        n_seg   = r_seg;
        n_flag  = r_flag;
        n_blank = r_blank;
        o_pop   = 1'b0;
        w_emit  = 1'b0;
        if (r_busy && w_adv) begin
            w_emit = 1'b1;
            // digit write: keep segment byte for the shifted write, move to next digit
            if (r_step > STEP_FLAG && r_step[0]) begin
                n_seg = w_seg;
                n_rem = w_split.rest;
                n_dig = r_dig + DIG_W'(1);
            end
            if (r_step == STEP_LAST) begin
                n_busy = i_q_valid;
                o_pop  = i_q_valid;
            end else begin
                n_step = r_step + STEP_W'(1);
            end
        end else if (!r_busy && i_q_valid) begin
            n_busy = 1'b1;
            o_pop  = 1'b1;
        end
        // load a fresh entry
        if (o_pop) begin
            n_step  = STEP_COL_HI;
            n_dig   = '0;
            n_rem   = i_job.value;
            n_flag  = i_job.flag;
            n_blank = i_job.blank;
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_COL_HI;
            r_dig  <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            r_dig  <= n_dig;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_seg   <= n_seg;
        r_flag  <= n_flag;
        r_blank <= n_blank;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_wr;
        end
    end

endmodule

// ----- hw/rtl/decimal_segment_field_writer.sv -----
// Decimal segment field writer: each item gives thirteen segment LCD controller writes.
// The first write of an item passes through the queue, the sequencer state and the output register.
// Throughput: one write per cycle while m_tready is high and items are queued, set by the back-end write sequencer.
// Up to two further items wait in the queue while a sequence runs.
// Reset (synchronous, active low) empties queue and output, and rearms the first-call flag.
// Depends on dsfw_pkg, dsfw_front, dsfw_queue and dsfw_back.
module decimal_segment_field_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] shown_value, [17:16] mode, [23:18] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] bus_byte
    output logic        m_tuser,   // [0] is_command
    output logic        m_tlast    // last write of the thirteen
);
    import dsfw_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_q_valid;
    t_job w_job_in;
    t_job w_job_out;
    t_wr  w_wr;

    dsfw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .i_value  (s_tdata[15:0]),
        .i_mode   (s_tdata[17:16]),
        .o_ready  (s_tready),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_job    (w_job_in)
    );

    dsfw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_job_out)
    );

    dsfw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_job     (w_job_out),
        .o_pop     (w_pop),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_wr      (w_wr)
    );

    assign m_tdata = w_wr.bus_byte;
    assign m_tuser = w_wr.is_command;
    assign m_tlast = w_wr.last;

endmodule
